// ===== rtl/ovs_pkg.sv =====
package ovs_pkg;

	localparam int TABLE_ENTRIES = 24;
	localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [31:0]        WARN_RESET  = 32'd524288;
	localparam logic [31:0]        CRIT_RESET  = 32'd131072;
	localparam logic signed [15:0] SCORE_FLOOR = -16'sd32768;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_FULL       = 3'd1,
		ST_NO_ACTION  = 3'd2,
		ST_CULLED     = 3'd3,
		ST_NO_VICTIM  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LVL_NONE     = 2'd0,
		LVL_WARN     = 2'd1,
		LVL_CRITICAL = 2'd2
	} level_t;

	typedef enum logic {
		OP_REGISTER = 1'b0,
		OP_SWEEP    = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_WARN = 1'b0,
		CFG_CRIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FETCH_LAST,
		S_MOVE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [31:0]        id;
		logic [31:0]        usage;
		logic signed [15:0] score;
		logic               prot;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		status_t            status;
		level_t             level;
		logic [31:0]        id;
		logic [31:0]        usage;
		logic signed [15:0] score;
		logic [4:0]         slot;
		logic [4:0]         count;
	} result_t;

endpackage

// ===== rtl/ovs_ram.sv =====
module ovs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/oom_victim_selector_unit.sv =====
// Memory-pressure victim selector.
// Input channel (in_valid/in_ready) carries one item per beat: opcode 0
// appends an entry (proc_id, usage_kb, cull_score, is_protected), opcode 1
// runs a sweep with free_kb. Every item yields exactly one result beat on
// the output channel (out_valid/out_ready).
// A register item, or a sweep that needs no scan, goes straight to the
// done state, which copies its result into the output register. A sweep
// that scans reads the entry table one entry per cycle from a
// single-port-read RAM, then reads the last entry and, if a victim was
// found, writes it over the victim. Items are processed one at a time;
// the next item is taken once the current result sits in the output
// register, so no new item is taken while one is still in progress. A new
// item can be accepted while the previous result still waits on out_ready.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
// always taken; index 0 is the warn threshold, index 1 the critical one.
// Reset empties the table (entry count zero, no clearing pass) and loads
// the default thresholds. A stalled receiver holds the output beat and,
// after the next item finishes, holds that item in its done state.
module oom_victim_selector_unit
	import ovs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [31:0]        proc_id,
	input  logic [31:0]        usage_kb,
	input  logic signed [15:0] cull_score,
	input  logic               is_protected,
	input  logic [31:0]        free_kb,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [1:0]         pressure_level,
	output logic [31:0]        victim_id,
	output logic [31:0]        victim_usage_kb,
	output logic signed [15:0] victim_score,
	output logic [4:0]         victim_slot,
	output logic [4:0]         entry_count
);

	fsm_t               state_q, state_d;
	logic [31:0]        warn_q, crit_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  last_slot;
	logic               rd_v_s1;
	logic [SLOT_W-1:0]  rd_slot_s1;
	logic               found_q;
	logic [SLOT_W-1:0]  slot_q;
	logic signed [15:0] best_q;
	entry_t             victim_q;
	level_t             level_q;
	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;

	logic               ram_we, ram_re;
	logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
	entry_t             ram_wdata, rd_entry;
	logic [ENTRY_W-1:0] rd_raw;

	logic               accept, is_full, no_action, better;
	entry_t             new_entry;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign is_full   = (count_q == CNT_W'(TABLE_ENTRIES));
	assign no_action = (free_kb > warn_q);
	assign last_slot = SLOT_W'(count_q - CNT_W'(1));
	assign rd_entry  = entry_t'(rd_raw);
	assign better    = rd_v_s1 && !rd_entry.prot && ($signed(rd_entry.score) > best_q);

	always_comb begin
		new_entry.id    = proc_id;
		new_entry.usage = usage_kb;
		new_entry.score = cull_score;
		new_entry.prot  = is_protected;
	end

	ovs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_raw)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_SWEEP && !no_action && count_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (idx_q == last_slot) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:      state_d = S_FETCH_LAST;
			S_FETCH_LAST: state_d = found_q ? S_MOVE : S_DONE;
			S_MOVE:       state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default:      state_d = S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[SLOT_W-1:0];
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ram_we   = in_valid && opcode == OP_REGISTER && !is_full;
			end
			S_SCAN: begin
				ram_re = 1'b1;
			end
			S_FETCH_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = last_slot;
			end
			S_MOVE: begin
				// last entry overwrites the victim slot
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = rd_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			warn_q      <= WARN_RESET;
			crit_q      <= CRIT_RESET;
			count_q     <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == S_SCAN);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WARN: warn_q <= cfg_data;
					CFG_CRIT: crit_q <= cfg_data;
					default:  warn_q <= warn_q;
				endcase
			end

			if (state_q == S_IDLE && accept && opcode == OP_REGISTER && !is_full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == S_MOVE) begin
				count_q <= count_q - CNT_W'(1);
			end

			if (state_q == S_IDLE) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end

			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath and pending result
	always_ff @(posedge clk) begin
		rd_slot_s1 <= idx_q;
		if (state_q == S_IDLE) begin
			idx_q  <= '0;
			best_q <= SCORE_FLOOR;
		end else if (state_q == S_SCAN) begin
			idx_q <= idx_q + SLOT_W'(1);
		end

		if (better) begin
			best_q   <= $signed(rd_entry.score);
			slot_q   <= rd_slot_s1;
			victim_q <= rd_entry;
		end

		if (state_q == S_IDLE && accept) begin
			res_q.id    <= '0;
			res_q.usage <= '0;
			res_q.score <= '0;
			res_q.slot  <= '0;
			res_q.level <= LVL_NONE;
			res_q.count <= 5'(count_q);
			if (opcode == OP_REGISTER) begin
				if (is_full) begin
					res_q.status <= ST_FULL;
				end else begin
					res_q.status <= ST_REGISTERED;
					res_q.count  <= 5'(count_q + CNT_W'(1));
				end
			end else if (no_action) begin
				res_q.status <= ST_NO_ACTION;
			end else begin
				res_q.status <= ST_NO_VICTIM;
				res_q.level  <= (free_kb < crit_q) ? LVL_CRITICAL : LVL_WARN;
			end
		end else if (state_q == S_MOVE) begin
			res_q.status <= ST_CULLED;
			res_q.id     <= victim_q.id;
			res_q.usage  <= victim_q.usage;
			res_q.score  <= victim_q.score;
			res_q.slot   <= 5'(slot_q);
			res_q.count  <= 5'(count_q - CNT_W'(1));
		end

		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign pressure_level  = out_q.level;
	assign victim_id       = out_q.id;
	assign victim_usage_kb = out_q.usage;
	assign victim_score    = out_q.score;
	assign victim_slot     = out_q.slot;
	assign entry_count     = out_q.count;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table size");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_MOVE))
		else $error("table write outside register or move");

	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("cull did not shrink the table");

	a_scan_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("scan data outside scan");

endmodule
